// ===== rtl/tfn_pkg.sv =====
// Shared constants for the triangle face normal pipeline.
package tfn_pkg;
  localparam int SCALE_BITS   = 31;
  localparam int SQ_W         = 2 * SCALE_BITS;
  localparam int L2_W         = 64;
  localparam int ROOT_W       = 32;
  localparam int REM_W        = ROOT_W + 3;
  localparam int OUT_W        = 16;
  localparam int SMALL_BITS   = 5;
  localparam int DEGEN_SQ_MAX = 281;
endpackage

// ===== rtl/triangle_face_normal_top.sv =====
// Top level: outward unit face normal of a fixed-point triangle, fully pipelined.
// Usage:
//   Input channel (in_valid/in_ready) carries one triangle per beat: vertices
//   (ax,ay,az), (bx,by_coord,bz), (cx,cy,cz) as signed Q11.12, plus mesh_end.
//   Output channel (out_valid/out_ready) carries one beat per triangle: the unit
//   normal nx, ny, nz in signed Q1.NORMAL_FRAC_BITS, degenerate, mesh_end_out.
//   Near-zero triangles give (0,0,1.0) with degenerate set.
// Pipeline: seven cross product and scaling stages, 32 square root stages
//   (one root bit each), NORMAL_FRAC_BITS + 2 divider stages (a setup stage,
//   then one quotient bit each, three lanes in parallel) and two orientation
//   stages.
// Throughput: one triangle per cycle unless the output stalls; a new beat enters every cycle while in_ready is high.
// Stall: all stages advance together; while a result waits in the output
//   register and out_ready is low, the pipeline holds and in_ready is low.
//   Nothing is dropped or repeated.
// Reset: clears all valid bits; the pipeline comes up empty and ready.
module triangle_face_normal_top #(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by_coord,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] cz,
  input  logic                          mesh_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tfn_pkg::OUT_W-1:0] nx,
  output logic signed [tfn_pkg::OUT_W-1:0] ny,
  output logic signed [tfn_pkg::OUT_W-1:0] nz,
  output logic                          degenerate,
  output logic                          mesh_end_out
);
  localparam int CW   = COORD_WIDTH;
  localparam int F    = NORMAL_FRAC_BITS;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int MW   = 2 * CW + 2;
  localparam int BLW  = $clog2(MW + 1);
  localparam int SB   = tfn_pkg::SCALE_BITS;
  localparam int SQW  = tfn_pkg::SQ_W;
  localparam int L2W  = tfn_pkg::L2_W;
  localparam int RW   = tfn_pkg::ROOT_W;
  localparam int OW   = tfn_pkg::OUT_W;
  localparam int QW   = F + 1;
  localparam int NW   = SB + F + 1;
  localparam int NSW  = F + 2;
  localparam int XW   = (NSW > OW) ? NSW : OW;
  localparam int DW   = CW + NSW + 2;
  localparam int SBW  = 3 * SB + 3 + 3 * CW + 2;
  localparam int TW   = 3 + 3 * CW + 2;
  localparam logic [XW-1:0] ONE = XW'(1) << F;

  logic en;

  // stage 1: edge vectors
  logic                 v1;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] f1 [3];
  logic signed [CW-1:0] a1 [3];
  logic                 me1;
  // stage 2: partial products
  logic                 v2;
  logic signed [PW-1:0] p2 [6];
  logic signed [CW-1:0] a2 [3];
  logic                 me2;
  // stage 3: magnitudes
  logic                 v3;
  logic signed [PW:0]   x3c [3];
  logic [MW-1:0]        mag3 [3];
  logic [2:0]           neg3;
  logic signed [CW-1:0] a3 [3];
  logic                 me3;
  // stage 4: bit length
  logic                 v4;
  logic [MW-1:0]        or4c;
  logic [BLW-1:0]       bl4c;
  logic [BLW-1:0]       bl4;
  logic [MW-1:0]        mag4 [3];
  logic [2:0]           neg4;
  logic signed [CW-1:0] a4 [3];
  logic                 me4;
  // stage 5: scaled magnitudes
  logic                 v5;
  logic [SB-1:0]        m5c [3];
  logic [BLW-1:0]       sh5c;
  logic [MW+SB-1:0]     up5c [3];
  logic [11:0]          ssq5c;
  logic [SB-1:0]        m5 [3];
  logic                 dg5;
  logic [2:0]           neg5;
  logic signed [CW-1:0] a5 [3];
  logic                 me5;
  // stage 6: squares
  logic                 v6;
  logic [SQW-1:0]       sq6 [3];
  logic [SB-1:0]        m6 [3];
  logic                 dg6;
  logic [2:0]           neg6;
  logic signed [CW-1:0] a6 [3];
  logic                 me6;
  // stage 7: squared length
  logic                 v7;
  logic [L2W-1:0]       l27;
  logic [SB-1:0]        m7 [3];
  logic                 dg7;
  logic [2:0]           neg7;
  logic signed [CW-1:0] a7 [3];
  logic                 me7;
  // square root
  logic                 sv;
  logic [RW-1:0]        slen;
  logic [SBW-1:0]       sb_in;
  logic [SBW-1:0]       sb_out;
  logic [SB-1:0]        sm [3];
  // divider
  logic                 dv   [QW+1];
  logic [RW-1:0]        dr   [QW+1][3];
  logic [QW-1:0]        dl   [QW+1][3];
  logic [QW-1:0]        dq   [QW+1][3];
  logic [RW-1:0]        dlen [QW+1];
  logic [TW-1:0]        dt   [QW+1];
  logic [NW-1:0]        num8c [3];
  // stage 9: signed normal and dot terms
  logic                 v9;
  logic [TW-1:0]        t_q;
  logic signed [NSW-1:0] n9c [3];
  logic signed [NSW-1:0] n9 [3];
  logic signed [DW-1:0]  pr9 [3];
  logic                 dg9;
  logic                 me9;
  // output stage
  logic signed [DW-1:0] dotc;
  logic                 flipc;
  logic [XW-1:0]        oc [3];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e1[0] <= EW'(bx) - EW'(ax);
      e1[1] <= EW'(by_coord) - EW'(ay);
      e1[2] <= EW'(bz) - EW'(az);
      f1[0] <= EW'(cx) - EW'(ax);
      f1[1] <= EW'(cy) - EW'(ay);
      f1[2] <= EW'(cz) - EW'(az);
      a1[0] <= ax;
      a1[1] <= ay;
      a1[2] <= az;
      me1   <= mesh_end;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2[2*i]   <= PW'(e1[(i+1)%3]) * PW'(f1[(i+2)%3]);
        p2[2*i+1] <= PW'(e1[(i+2)%3]) * PW'(f1[(i+1)%3]);
        a2[i]     <= a1[i];
      end
      me2 <= me1;
    end
  end

  // stage 3
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x3c[i] = (PW+1)'(p2[2*i]) - (PW+1)'(p2[2*i+1]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= x3c[i][PW];
        mag3[i] <= x3c[i][PW] ? MW'(-x3c[i]) : MW'(x3c[i]);
        a3[i]   <= a2[i];
      end
      me3 <= me2;
    end
  end

  // stage 4
  always_comb begin
    or4c = mag3[0] | mag3[1] | mag3[2];
    bl4c = '0;
    for (int k = 0; k < MW; k++) begin
      if (or4c[k]) begin
        bl4c = BLW'(k + 1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bl4  <= bl4c;
      mag4 <= mag3;
      neg4 <= neg3;
      a4   <= a3;
      me4  <= me3;
    end
  end

  // stage 5
  always_comb begin
    ssq5c = '0;
    if (bl4 > BLW'(SB)) begin
      sh5c = bl4 - BLW'(SB);
    end else begin
      sh5c = BLW'(SB) - bl4;
    end
    for (int i = 0; i < 3; i++) begin
      up5c[i] = (MW+SB)'(mag4[i]) << sh5c;
      if (bl4 > BLW'(SB)) begin
        m5c[i] = SB'(mag4[i] >> sh5c);
      end else begin
        m5c[i] = up5c[i][SB-1:0];
      end
      ssq5c = ssq5c + 12'(mag4[i][tfn_pkg::SMALL_BITS-1:0])
                    * 12'(mag4[i][tfn_pkg::SMALL_BITS-1:0]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m5   <= m5c;
      dg5  <= (bl4 <= BLW'(tfn_pkg::SMALL_BITS))
              && (ssq5c <= 12'(tfn_pkg::DEGEN_SQ_MAX));
      neg5 <= neg4;
      a5   <= a4;
      me5  <= me4;
    end
  end

  // stage 6
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= SQW'(m5[i]) * SQW'(m5[i]);
      end
      m6   <= m5;
      dg6  <= dg5;
      neg6 <= neg5;
      a6   <= a5;
      me6  <= me5;
    end
  end

  // stage 7
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l27  <= L2W'(sq6[0]) + L2W'(sq6[1]) + L2W'(sq6[2]);
      m7   <= m6;
      dg7  <= dg6;
      neg7 <= neg6;
      a7   <= a6;
      me7  <= me6;
    end
  end

  assign sb_in = {m7[0], m7[1], m7[2], neg7, a7[0], a7[1], a7[2], dg7, me7};

  tfn_isqrt #(
    .SBW(SBW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v7),
    .in_x     (l27),
    .in_sb    (sb_in),
    .out_valid(sv),
    .out_root (slen),
    .out_sb   (sb_out)
  );

  assign sm[0] = sb_out[SBW-1 -: SB];
  assign sm[1] = sb_out[SBW-1-SB -: SB];
  assign sm[2] = sb_out[SBW-1-2*SB -: SB];

  // divider setup: numerator with rounding half, top part as first remainder
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num8c[i] = (NW'(sm[i]) << F) + NW'(slen >> 1);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dr[0][i] <= RW'(num8c[i][NW-1:QW]);
        dl[0][i] <= num8c[i][QW-1:0];
        dq[0][i] <= '0;
      end
      dlen[0] <= slen;
      dt[0]   <= sb_out[TW-1:0];
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_div
    logic [RW:0] t [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {dr[s-1][i], dl[s-1][i][QW-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s] <= 1'b0;
      end else if (en) begin
        dv[s] <= dv[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dl[s][i] <= dl[s-1][i] << 1;
          if (t[i] >= {1'b0, dlen[s-1]}) begin
            dr[s][i] <= RW'(t[i] - {1'b0, dlen[s-1]});
            dq[s][i] <= {dq[s-1][i][QW-2:0], 1'b1};
          end else begin
            dr[s][i] <= RW'(t[i]);
            dq[s][i] <= {dq[s-1][i][QW-2:0], 1'b0};
          end
        end
        dlen[s] <= dlen[s-1];
        dt[s]   <= dt[s-1];
      end
    end
  end

  // stage 9
  assign t_q = dt[QW];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (t_q[TW-3+i]) begin
        n9c[i] = -$signed(NSW'(dq[QW][i]));
      end else begin
        n9c[i] = $signed(NSW'(dq[QW][i]));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= dv[QW];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n9[i]  <= n9c[i];
        pr9[i] <= DW'($signed(t_q[2+(3-i)*CW-1 -: CW])) * DW'(n9c[i]);
      end
      dg9 <= t_q[1];
      me9 <= t_q[0];
    end
  end

  // output stage: orientation flip
  always_comb begin
    dotc  = pr9[0] + pr9[1] + pr9[2];
    flipc = !dg9 && dotc[DW-1];
    for (int i = 0; i < 3; i++) begin
      if (dg9) begin
        oc[i] = (i == 2) ? ONE : '0;
      end else if (flipc) begin
        oc[i] = XW'(-n9[i]);
      end else begin
        oc[i] = XW'(n9[i]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v9;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx           <= oc[0][OW-1:0];
      ny           <= oc[1][OW-1:0];
      nz           <= oc[2][OW-1:0];
      degenerate   <= dg9;
      mesh_end_out <= me9;
    end
  end
endmodule

// ===== rtl/tfn_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband.
module tfn_isqrt #(
  parameter int SBW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [tfn_pkg::L2_W-1:0]   in_x,
  input  logic [SBW-1:0]             in_sb,
  output logic                       out_valid,
  output logic [tfn_pkg::ROOT_W-1:0] out_root,
  output logic [SBW-1:0]             out_sb
);
  localparam int RW = tfn_pkg::ROOT_W;
  localparam int MW = tfn_pkg::REM_W;
  localparam int XW = tfn_pkg::L2_W;

  logic          v    [RW+1];
  logic [MW-1:0] rem  [RW+1];
  logic [RW-1:0] root [RW+1];
  logic [XW-1:0] xr   [RW+1];
  logic [SBW-1:0] sb  [RW+1];

  assign v[0]    = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xr[0]   = in_x;
  assign sb[0]   = in_sb;

  for (genvar s = 1; s <= RW; s++) begin : g_stage
    logic [MW-1:0] rem_t;
    logic [MW-1:0] trial;
    always_comb begin
      rem_t = {rem[s-1][MW-3:0], xr[s-1][XW-1 -: 2]};
      trial = MW'({root[s-1], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xr[s] <= {xr[s-1][XW-3:0], 2'b00};
        sb[s] <= sb[s-1];
        if (rem_t >= trial) begin
          rem[s]  <= rem_t - trial;
          root[s] <= {root[s-1][RW-2:0], 1'b1};
        end else begin
          rem[s]  <= rem_t;
          root[s] <= {root[s-1][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[RW];
  assign out_root  = root[RW];
  assign out_sb    = sb[RW];
endmodule

// ===== rtl/tfn_checker.sv =====
// Port-level checker for the face normal block, bound to the top level.
module tfn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tfn_pkg::OUT_W-1:0]     nx,
  input logic [tfn_pkg::OUT_W-1:0]     ny,
  input logic [tfn_pkg::OUT_W-1:0]     nz,
  input logic                          degenerate,
  input logic                          mesh_end_out
);
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track the output stall");

  a_degen_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> nx == '0 && ny == '0)
    else $error("degenerate beat carries a nonzero x or y");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(nx) && $stable(ny) && $stable(nz)
      && $stable(degenerate) && $stable(mesh_end_out))
    else $error("output payload changed while stalled");
endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the triangle face normal pipeline.
`timescale 1ns / 100ps
module tb;
  localparam int CW = 24;
  localparam int FB = 14;
  localparam int LIMIT = 400000;
  localparam int MX = 8388607;
  localparam int MN = -8388608;

  typedef struct {
    logic [CW-1:0] v[9];
    logic          me;
  } tri_t;

  typedef struct {
    logic signed [tfn_pkg::OUT_W-1:0] nx, ny, nz;
    logic                    degen;
    logic                    me;
  } normal_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [CW-1:0] ax = 0, ay = 0, az = 0, bx = 0, by_coord = 0, bz = 0;
  logic signed [CW-1:0] cx = 0, cy = 0, cz = 0;
  logic mesh_end = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [tfn_pkg::OUT_W-1:0] nx, ny, nz;
  logic degenerate, mesh_end_out;

  tri_t    pending_tris[$];
  normal_t expected_normals[$];
  int      fails = 0;
  int      cyc = 0;
  int      sent = 0;
  bit      drained = 0;

  triangle_face_normal_top #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by_coord(by_coord), .bz(bz),
    .cx(cx), .cy(cy), .cz(cz), .mesh_end(mesh_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .nx(nx), .ny(ny), .nz(nz), .degenerate(degenerate), .mesh_end_out(mesh_end_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(tri_t t);
    longint a[3], e[3], f[3], n[3], dot;
    logic signed [127:0] x;
    logic [127:0] mag[3];
    bit neg[3];
    longint unsigned m[3], l2, len, q;
    int maxbl, bl, sh, j, k;
    normal_t r;
    maxbl = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(t.v[i]));
      e[i] = longint'($signed(t.v[3+i])) - a[i];
      f[i] = longint'($signed(t.v[6+i])) - a[i];
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      x = 128'(e[j]) * 128'(f[k]) - 128'(e[k]) * 128'(f[j]);
      neg[i] = x[127];
      mag[i] = neg[i] ? -x : x;
      bl = 0;
      for (int b = 0; b < 128; b++) if (mag[i][b]) bl = b + 1;
      if (bl > maxbl) maxbl = bl;
    end
    r.degen = 0;
    if (maxbl > tfn_pkg::SCALE_BITS) begin
      sh = maxbl - tfn_pkg::SCALE_BITS;
      for (int i = 0; i < 3; i++) m[i] = 64'(mag[i] >> sh);
    end else begin
      l2 = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = 64'(mag[i]);
        l2 += m[i] * m[i];
      end
      r.degen = l2 <= tfn_pkg::DEGEN_SQ_MAX;
      if (!r.degen) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] << (tfn_pkg::SCALE_BITS - maxbl);
      end
    end
    if (r.degen) begin
      n[0] = 0;
      n[1] = 0;
      n[2] = 64'd1 << FB;
    end else begin
      l2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = floor_root(l2);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << FB) + (len >> 1)) / len;
        n[i] = neg[i] ? -longint'(q) : longint'(q);
        dot += a[i] * n[i];
      end
      if (dot < 0) for (int i = 0; i < 3; i++) n[i] = -n[i];
    end
    r.nx = n[0][tfn_pkg::OUT_W-1:0];
    r.ny = n[1][tfn_pkg::OUT_W-1:0];
    r.nz = n[2][tfn_pkg::OUT_W-1:0];
    r.me = t.me;
    return r;
  endfunction

  function automatic logic [CW-1:0] jitter(int amp);
    return CW'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  function automatic tri_t make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                    int c0, int c1, int c2, bit me);
    tri_t t;
    t.v[0] = CW'(a0); t.v[1] = CW'(a1); t.v[2] = CW'(a2);
    t.v[3] = CW'(b0); t.v[4] = CW'(b1); t.v[5] = CW'(b2);
    t.v[6] = CW'(c0); t.v[7] = CW'(c1); t.v[8] = CW'(c2);
    t.me = me;
    return t;
  endfunction

  task automatic queue_tri(tri_t t);
    pending_tris = {pending_tris, t};
  endtask

  initial begin
    tri_t t;
    int kind, amp;
    queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tri(make_tri(5, 5, 5, 10, 10, 10, 20, 20, 20, 1));
    queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 16, 0, 0));
    queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 17, 0, 0));
    queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0));
    queue_tri(make_tri(7, 7, 7, 8, 7, 7, 7, 24, 7, 1));
    queue_tri(make_tri(MN, MN, MN, MX, MN, MN, MN, MX, MN, 0));
    queue_tri(make_tri(MX, MX, MX, MN, MX, MX, MX, MN, MX, 1));
    queue_tri(make_tri(MN, MX, MN, MX, MN, MX, MN, MN, MX, 0));
    queue_tri(make_tri(MX, MN, MX, MN, MX, MN, MX, MX, MN, 0));
    queue_tri(make_tri(0, 0, 4096, 4096, 0, 4096, 0, 4096, 4096, 0));
    queue_tri(make_tri(0, 0, 4096, 0, 4096, 4096, 4096, 0, 4096, 0));
    queue_tri(make_tri(0, 0, -4096, 4096, 0, -4096, 0, 4096, -4096, 1));
    queue_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0));
    queue_tri(make_tri(4096, 0, 0, 4096, 4096, 0, 4096, 0, 4096, 0));
    queue_tri(make_tri(-4096, 0, 0, -4096, 4096, 0, -4096, 0, 4096, 1));
    for (int n = 0; n < 1400; n++) begin
      kind = $urandom_range(0, 9);
      amp = 1 << $urandom_range(0, 22);
      for (int i = 0; i < 3; i++) t.v[i] = CW'($urandom);
      if (kind < 4) begin
        for (int i = 3; i < 9; i++) t.v[i] = CW'($urandom);
      end else if (kind < 8) begin
        if (kind == 7) amp = $urandom_range(1, 4);
        for (int i = 3; i < 9; i++) t.v[i] = t.v[i%3] + jitter(amp);
      end else begin
        for (int i = 0; i < 3; i++) begin
          t.v[3+i] = t.v[i] + jitter(amp >> 1);
          t.v[6+i] = CW'(t.v[i] + 2 * (t.v[3+i] - t.v[i]));
        end
      end
      t.me = 1'($urandom_range(0, 1));
      queue_tri(t);
    end
    repeat (11) @(posedge clk);
    rst <= 0;
    wait (pending_tris.size() == 0 && !in_valid && expected_normals.size() == 0);
    repeat (120) @(posedge clk);
    if (fails == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  always @(posedge clk) begin
    tri_t t;
    bit quiet, hold;
    quiet = sent >= 500 && sent < 800;
    hold = sent == 900 && !drained;
    if (hold && expected_normals.size() == 0) drained <= 1;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (pending_tris.size() != 0 && !hold && (quiet || $urandom_range(0, 99) >= 23)) begin
        t = pending_tris.pop_front();
        ax <= t.v[0]; ay <= t.v[1]; az <= t.v[2];
        bx <= t.v[3]; by_coord <= t.v[4]; bz <= t.v[5];
        cx <= t.v[6]; cy <= t.v[7]; cz <= t.v[8];
        mesh_end <= t.me;
        expected_normals = {expected_normals, face_normal(t)};
        sent <= sent + 1;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    normal_t x;
    bit quiet;
    quiet = sent >= 500 && sent < 800;
    out_ready <= rst ? 1'b0 : (quiet || $urandom_range(0, 99) >= 23);
    if (!rst && out_valid && out_ready) begin
      if (expected_normals.size() == 0) begin
        $error("result with nothing expected");
        fails++;
      end else begin
        x = expected_normals.pop_front();
        if (nx !== x.nx) begin $error("nx exp %0d got %0d", x.nx, nx); fails++; end
        if (ny !== x.ny) begin $error("ny exp %0d got %0d", x.ny, ny); fails++; end
        if (nz !== x.nz) begin $error("nz exp %0d got %0d", x.nz, nz); fails++; end
        if (degenerate !== x.degen) begin
          $error("degenerate exp %0d got %0d", x.degen, degenerate);
          fails++;
        end
        if (mesh_end_out !== x.me) begin
          $error("mesh_end_out exp %0d got %0d", x.me, mesh_end_out);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end
endmodule
